[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define HBC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hbc assertion failed");

// Check a property on every rising edge, reset included.
`define HBC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hbc assertion failed");

`endif

[rtl/hbc_pkg.sv]
// Types, constants and helper functions of the Hill cipher block.
package hbc_pkg;

    // Key storage and letter coding
    localparam int KEY_DIM     = 4;
    localparam int KEY_IDX_W   = $clog2(KEY_DIM);
    localparam int DIM_W       = 3;
    localparam int LETTER_W    = 5;
    localparam int KEY_ROW_W   = KEY_DIM * LETTER_W;
    localparam int CFG_DATA_W  = KEY_ROW_W;
    localparam int CFG_IDX_W   = 3;
    localparam int SUM_W       = 12;

    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;
    localparam logic [7:0]          UPPER_BASE = 8'd65;
    localparam logic [7:0]          LOWER_BASE = 8'd97;
    localparam logic [7:0]          UPPER_LAST = 8'd90;
    localparam logic [7:0]          LOWER_LAST = 8'd122;
    localparam logic [SUM_W-1:0]    MODULUS    = 12'd26;

    // Block queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECRYPT = 3'd0,
        CFG_ROWS    = 3'd1,
        CFG_COLS    = 3'd2,
        CFG_KEY0    = 3'd3,
        CFG_KEY1    = 3'd4,
        CFG_KEY2    = 3'd5,
        CFG_KEY3    = 3'd6
    } t_cfg_idx;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SUM,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_block;
    } t_out_beat;

    typedef logic [KEY_DIM-1:0][LETTER_W-1:0] t_block;

    typedef struct packed {
        logic   valid;
        t_block blk;
    } t_blk_push;

    typedef struct packed {
        logic                             decrypt;
        logic [DIM_W-1:0]                 rows;
        logic [DIM_W-1:0]                 cols;
        logic [KEY_DIM-1:0][KEY_ROW_W-1:0] keys;
    } t_cfg;

    // Map a raw dimension onto 1..lim
    function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = 3'd1;
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

[rtl/hbc_front.sv]
// Front end: classifies text bytes, gathers letters and hands full blocks on.
module hbc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hbc_pkg::t_in_beat i_in_beat,
    input  hbc_pkg::t_cfg     i_cfg,
    input  logic              i_q_ready,
    output hbc_pkg::t_blk_push o_push
);
    import hbc_pkg::*;

    t_block           r_buf, n_buf;
    logic [DIM_W-1:0] r_fill, n_fill;

    logic             accept;
    logic             is_upper;
    logic             is_lower;
    logic [7:0]       diff;
    logic [DIM_W-1:0] fill_inc;

    // Take a beat only when a finished block would find room
    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the byte and compute its letter value
    always_comb begin
        is_upper = (i_in_beat.char_in >= UPPER_BASE) && (i_in_beat.char_in <= UPPER_LAST);
        is_lower = (i_in_beat.char_in >= LOWER_BASE) && (i_in_beat.char_in <= LOWER_LAST);
        diff     = is_upper ? (i_in_beat.char_in - UPPER_BASE)
                            : (i_in_beat.char_in - LOWER_BASE);
        fill_inc = r_fill + 3'd1;
    end

    // Gather letters, pad or drop on end of text, push complete blocks
    always_comb begin
        n_buf        = r_buf;
        n_fill       = r_fill;
        o_push.valid = 1'b0;
        o_push.blk   = r_buf;
        if (accept) begin
            if (i_in_beat.end_of_text) begin
                if (r_fill != '0) begin
                    n_fill = '0;
                    if (!i_cfg.decrypt) begin
                        o_push.valid = 1'b1;
                        for (int c = 0; c < KEY_DIM; c++) begin
                            if (DIM_W'(c) >= r_fill) begin
                                o_push.blk[c] = PAD_LETTER;
                            end
                        end
                    end
                end
            end else if (is_upper || is_lower) begin
                if (r_fill < DIM_W'(KEY_DIM)) begin
                    n_buf[r_fill[KEY_IDX_W-1:0]] = diff[LETTER_W-1:0];
                end
                if (fill_inc >= i_cfg.cols) begin
                    o_push.valid = 1'b1;
                    o_push.blk   = n_buf;
                    n_fill       = '0;
                end else begin
                    n_fill = fill_inc;
                end
            end
        end
    end

    // Hold the letter buffer
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    // Advance the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

[rtl/hbc_queue.sv]
// Short block queue that decouples the front end from the back end.
module hbc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbc_pkg::t_blk_push i_push,
    output logic               o_ready,
    output logic               o_valid,
    output hbc_pkg::t_block    o_blk,
    input  logic               i_pop
);
    import hbc_pkg::*;

    t_block            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_blk   = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Store pushed blocks
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.blk;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/hbc_back.sv]
// Back end: one key row dot product and mod 26 reduction per output letter.
module hbc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbc_pkg::t_cfg      i_cfg,
    input  logic               i_q_valid,
    input  hbc_pkg::t_block    i_q_blk,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hbc_pkg::t_out_beat o_out_beat
);
    import hbc_pkg::*;

    t_back_state          r_state, n_state;
    t_block               r_blk;
    logic [KEY_IDX_W-1:0] r_row, n_row;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out_beat, n_out_beat;

    logic [SUM_W-1:0]     dot;
    logic [19:0]          q_scaled;
    logic [6:0]           quot;
    logic [SUM_W-1:0]     rem0;
    logic [SUM_W-1:0]     rem1;
    logic                 out_free;
    logic                 last_row;
    logic [KEY_ROW_W-1:0] key_row;

    // Dot product of the current key row with the held block
    always_comb begin
        key_row = i_cfg.keys[r_row];
        dot     = '0;
        for (int c = 0; c < KEY_DIM; c++) begin
            if (DIM_W'(c) < i_cfg.cols) begin
                dot = dot + SUM_W'(key_row[c*LETTER_W +: LETTER_W] * r_blk[c]);
            end
        end
    end

    // Reduce the registered sum mod 26: reciprocal estimate, one correction
    always_comb begin
        q_scaled = 20'(r_sum) * 20'd315;
        quot     = q_scaled[19:13];
        rem0     = r_sum - SUM_W'(quot * 7'd26);
        rem1     = (rem0 >= MODULUS) ? (rem0 - MODULUS) : rem0;
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign last_row = ((DIM_W'(r_row) + 3'd1) == i_cfg.rows);

    // Sequence rows of a block and drive the output register
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        o_q_pop     = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_row   = '0;
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_beat.out_char      = (i_cfg.decrypt ? LOWER_BASE : UPPER_BASE)
                                               + 8'(rem1);
                    n_out_beat.last_of_block = last_row;
                    if (last_row) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = BK_SUM;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Hold state, row index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the block, the sum and the output payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_blk <= i_q_blk;
        end
        if (r_state == BK_SUM) begin
            r_sum <= dot;
        end
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

[rtl/hill_block_cipher_mod26_top.sv]
// Hill cipher mod 26 block: configuration registers, front end, block queue, back end.
//
// Text bytes enter one a cycle while the two-block queue has room; letters of either
// case are gathered into blocks of cols_in_use letters and other bytes are dropped.
// The back end takes a block from the queue, then for each output letter forms the
// key row dot product in a registered sum and reduces it mod 26 into the output
// register, holding while the output is stalled. Input stalls only when the queue
// holds two unprocessed blocks. Configuration is written through a plain write port
// and must only change while the block is idle. Load the inverse key for decryption.
module hill_block_cipher_mod26_top #(
    parameter int MAX_DIM = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hbc_pkg::t_in_beat                 i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hbc_pkg::t_out_beat                o_out_beat,
    input  logic                              i_cfg_we,
    input  logic [hbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hbc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hbc_pkg::*;

    localparam int LIM_RAW = (MAX_DIM < KEY_DIM) ? MAX_DIM : KEY_DIM;
    localparam int LIM_INT = (LIM_RAW < 1) ? 1 : LIM_RAW;
    localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(LIM_INT);

    logic                              r_decrypt;
    logic [DIM_W-1:0]                  r_rows;
    logic [DIM_W-1:0]                  r_cols;
    logic [KEY_DIM-1:0][KEY_ROW_W-1:0] r_keys;

    t_cfg      cfg;
    t_blk_push push;
    logic      q_ready;
    logic      q_valid;
    t_block    q_blk;
    logic      q_pop;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_rows    <= 3'd4;
            r_cols    <= 3'd4;
            r_keys    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DECRYPT: r_decrypt <= i_cfg_data[0];
                CFG_ROWS:    r_rows    <= i_cfg_data[DIM_W-1:0];
                CFG_COLS:    r_cols    <= i_cfg_data[DIM_W-1:0];
                CFG_KEY0:    r_keys[0] <= i_cfg_data[KEY_ROW_W-1:0];
                CFG_KEY1:    r_keys[1] <= i_cfg_data[KEY_ROW_W-1:0];
                CFG_KEY2:    r_keys[2] <= i_cfg_data[KEY_ROW_W-1:0];
                CFG_KEY3:    r_keys[3] <= i_cfg_data[KEY_ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp dimensions into the usable range
    always_comb begin
        cfg.decrypt = r_decrypt;
        cfg.rows    = dim_limit(r_rows, DIM_LIM);
        cfg.cols    = dim_limit(r_cols, DIM_LIM);
        cfg.keys    = r_keys;
    end

    hbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_cfg      (cfg),
        .i_q_ready  (q_ready),
        .o_push     (push)
    );

    hbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_blk   (q_blk),
        .i_pop   (q_pop)
    );

    hbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_blk     (q_blk),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

[rtl/hbc_checker.sv]
// Port-level checker for the Hill cipher block, bound to the top level.
`include "assert_macros.svh"

module hbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input hbc_pkg::t_out_beat o_out_beat
);
    import hbc_pkg::*;

    logic out_is_upper;
    logic out_is_lower;
    logic out_is_letter;

    // Classify the offered character
    assign out_is_upper  = (o_out_beat.out_char >= UPPER_BASE)
                        && (o_out_beat.out_char <= UPPER_LAST);
    assign out_is_lower  = (o_out_beat.out_char >= LOWER_BASE)
                        && (o_out_beat.out_char <= LOWER_LAST);
    assign out_is_letter = out_is_upper || out_is_lower;

    // A waiting result beat stays offered
    `HBC_ASSERT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)

    // A stalled result beat keeps its payload
    `HBC_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_beat))

    // Every result is a letter of one case or the other
    `HBC_ASSERT(a_out_letter, i_clk, i_rst_n, o_out_valid |-> out_is_letter)

    // Reset empties the output register
    `HBC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind hill_block_cipher_mod26_top hbc_checker u_hbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);
